@@ hw/rtl/hmf_pkg.sv @@
// hmf_pkg: shared constants for the histogram mode finder.
// No dependencies; imported by histogram_mode_finder_core.
`timescale 1ns / 1ps
`default_nettype none

package hmf_pkg;

	// Default sizing
	localparam int NUM_BINS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths on the ports
	localparam int VALUE_BITS     = 8;
	localparam int OUT_COUNT_BITS = 16;
	localparam int IN_DATA_BITS   = 8;
	localparam int OUT_DATA_BITS  = 24;

	// Bins reachable by an 8-bit value
	localparam int VALUE_SPAN     = 1 << VALUE_BITS;

endpackage : hmf_pkg

`default_nettype wire

@@ hw/rtl/histogram_mode_finder_core.sv @@
// histogram_mode_finder_core: mode of a frame of small values via a counting histogram.
// Depends on hmf_pkg (field widths, parameter defaults).
// Histogram lives in one synchronous RAM; per-bin valid bits give the per-frame clear.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] value, s_tlast ends the frame
//  m_*     | out | m_tvalid/m_tready  | m_tdata[7:0] mode_value, [23:8] mode_count
//
// One beat per cycle sustained unless a frame-closing beat stalls. A beat reads its bin
// at acceptance; stage 1 bumps, writes back and folds the count into the running best.
// Back-to-back beats to the same bin are forwarded from the write side.
// Only a frame-closing beat can stall: it waits while the output register is full
// and m_tready is low; other beats flow freely. Reset clears the bin valid bits,
// best registers and handshake state at once; no clearing pass is needed.
// Frame end clears all bin valid bits in the same cycle the result is loaded.

module histogram_mode_finder_core
	import hmf_pkg::*;
#(
	parameter int NUM_BINS   = NUM_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,   // [7:0] value
	input  wire logic                     s_tlast,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic      [OUT_DATA_BITS-1:0] m_tdata    // [7:0] mode_value, [23:8] mode_count
);

	// Only values below 2^VALUE_BITS can ever hit a bin
	localparam int DEPTH = (NUM_BINS < VALUE_SPAN) ? NUM_BINS : VALUE_SPAN;
	localparam int IDX_W = $clog2(DEPTH);

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// Histogram RAM and per-bin valid bits
	cnt_t             hist_mem [DEPTH];
	logic [DEPTH-1:0] bin_vld_q;

	// Stage 1 (bin data returned from RAM)
	logic                  valid_s1;
	logic                  last_s1;
	logic                  inr_s1;
	logic [VALUE_BITS-1:0] value_s1;
	idx_t                  idx_s1;
	cnt_t                  rd_s1;
	logic                  fwd_s1;
	cnt_t                  fwd_cnt_s1;

	// Running best
	cnt_t                  best_cnt_q;
	logic [VALUE_BITS-1:0] best_val_q;

	// Output register
	logic                      out_vld_q;
	logic [VALUE_BITS-1:0]     out_val_q;
	logic [OUT_COUNT_BITS-1:0] out_cnt_q;

	logic                      in_fire;
	logic                      in_range;
	idx_t                      in_idx;
	logic                      adv_s1;
	logic                      wr_en;
	logic                      frame_done;
	cnt_t                      old_cnt;
	cnt_t                      new_cnt;
	cnt_t                      best_cnt_n;
	logic [VALUE_BITS-1:0]     best_val_n;
	logic [OUT_COUNT_BITS-1:0] res_cnt;

	// Handshake: only a closing beat waits on the output register
	assign adv_s1     = !(last_s1 && out_vld_q && !m_tready);
	assign s_tready   = !valid_s1 || adv_s1;
	assign in_fire    = s_tvalid && s_tready;
	assign in_range   = (32'(s_tdata) < NUM_BINS);
	assign in_idx     = idx_t'(s_tdata);
	assign wr_en      = valid_s1 && adv_s1 && inr_s1;
	assign frame_done = valid_s1 && adv_s1 && last_s1;

	// Bin update and best tracking
	always_comb begin
		if (fwd_s1) begin
			old_cnt = fwd_cnt_s1;
		end else if (bin_vld_q[idx_s1]) begin
			old_cnt = rd_s1;
		end else begin
			old_cnt = '0;
		end
		new_cnt = (old_cnt == '1) ? old_cnt : old_cnt + cnt_t'(1);

		best_cnt_n = best_cnt_q;
		best_val_n = best_val_q;
		if (inr_s1) begin
			if (new_cnt > best_cnt_q) begin
				best_cnt_n = new_cnt;
				best_val_n = value_s1;
			end else if (new_cnt == best_cnt_q && value_s1 < best_val_q) begin
				best_val_n = value_s1;
			end
		end

		// Clamp wide counts to the output field
		if (COUNT_BITS > OUT_COUNT_BITS && (best_cnt_n >> OUT_COUNT_BITS) != '0) begin
			res_cnt = '1;
		end else begin
			res_cnt = OUT_COUNT_BITS'(best_cnt_n);
		end
	end

	// RAM: one write, one registered read per cycle (read-before-write)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[idx_s1] <= new_cnt;
		end
		if (in_fire) begin
			rd_s1 <= hist_mem[in_idx];
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_s1   <= s_tdata;
			idx_s1     <= in_idx;
			inr_s1     <= in_range;
			last_s1    <= s_tlast;
			// Same bin written this edge: RAM read is stale, take the new count
			fwd_s1     <= wr_en && !last_s1 && (idx_s1 == in_idx);
			fwd_cnt_s1 <= new_cnt;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			bin_vld_q  <= '0;
			best_cnt_q <= '0;
			best_val_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end

			if (frame_done) begin
				bin_vld_q <= '0;
			end else if (wr_en) begin
				bin_vld_q[idx_s1] <= 1'b1;
			end

			if (frame_done) begin
				best_cnt_q <= '0;
				best_val_q <= '0;
			end else if (valid_s1 && adv_s1) begin
				best_cnt_q <= best_cnt_n;
				best_val_q <= best_val_n;
			end

			if (frame_done) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (frame_done) begin
			out_val_q <= best_val_n;
			out_cnt_q <= res_cnt;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_cnt_q, out_val_q};

endmodule : histogram_mode_finder_core

`default_nettype wire

@@ sim/histogram_mode_finder_core_test.sv @@
// Self-checking testbench for histogram_mode_finder_core: frames of values in, mode out.
// Depends on hmf_pkg and histogram_mode_finder_core; the expected modes come from an
// in-bench histogram of each frame, checked beat by beat against the output stream.
`timescale 1ns / 1ps

module histogram_mode_finder_core_test;
	import hmf_pkg::*;

	localparam int BINS           = NUM_BINS_DEF;
	localparam int CNT_BITS       = COUNT_BITS_DEF;
	localparam int RANDOM_BEATS   = 1120;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int OUT_COUNT_MAX  = (1 << OUT_COUNT_BITS) - 1;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} sample_beat_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]     mode_value;
		logic [OUT_COUNT_BITS-1:0] mode_count;
	} mode_result_t;

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
	logic                     s_tlast  = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;

	histogram_mode_finder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stimulus and expectations
	sample_beat_t pending_beats[$];
	mode_result_t expected_modes[$];
	int           beats_total  = 0;
	int           beats_in     = 0;
	int           modes_seen   = 0;
	int           mismatches   = 0;
	int           stall_cycles = 0;

	// Frame histogram kept by the bench
	logic [CNT_BITS-1:0]   bin_tally [BINS];
	logic [CNT_BITS-1:0]   lead_count = '0;
	logic [VALUE_BITS-1:0] lead_value = '0;

	// Bump the bin, fold into the running mode; on frame end queue the mode and clear.
	function automatic void count_sample(input sample_beat_t b);
		logic [CNT_BITS-1:0] c;
		mode_result_t        r;
		longint              lc;
		if (int'(b.value) < BINS) begin
			c = bin_tally[b.value];
			if (c != '1)
				c = c + 1'b1;
			bin_tally[b.value] = c;
			if (c > lead_count) begin
				lead_count = c;
				lead_value = b.value;
			end else if (c == lead_count && b.value < lead_value) begin
				lead_value = b.value;
			end
		end
		if (b.last) begin
			lc           = longint'(lead_count);
			r.mode_value = lead_value;
			r.mode_count = (lc > OUT_COUNT_MAX) ? '1 : OUT_COUNT_BITS'(lc);
			expected_modes.push_back(r);
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			lead_count = '0;
			lead_value = '0;
		end
	endfunction

	function automatic void push_beat(input int value, input bit last);
		sample_beat_t b;
		b.value = VALUE_BITS'(value);
		b.last  = last;
		pending_beats.push_back(b);
		beats_total++;
	endfunction

	// Gap before the next beat; burst stretches give back-to-back traffic.
	function automatic int draw_gap(input bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	// Source side: accept at the rising edge, present the next beat at the falling edge
	bit send_busy  = 1'b0;
	bit send_burst = 1'b0;
	int send_gap   = 0;

	always @(posedge clk) begin
		sample_beat_t b;
		if (arst_n && s_tvalid && s_tready) begin
			b.value = s_tdata[VALUE_BITS-1:0];
			b.last  = s_tlast;
			count_sample(b);
			beats_in++;
			send_busy = 1'b0;
			if ($urandom_range(0, 63) == 0)
				send_burst = !send_burst;
			send_gap = draw_gap(send_burst);
		end
	end

	always @(negedge clk) begin
		sample_beat_t b;
		if (arst_n && !send_busy) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				s_tdata   <= b.value;
				s_tlast   <= b.last;
				s_tvalid  <= 1'b1;
				send_busy = 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: check each result beat against the oldest expected mode
	bit recv_burst = 1'b0;
	int recv_gap   = 0;

	always @(posedge clk) begin
		mode_result_t got;
		mode_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mode_value = m_tdata[VALUE_BITS-1:0];
			got.mode_count = m_tdata[VALUE_BITS +: OUT_COUNT_BITS];
			modes_seen++;
			if (expected_modes.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual value %0d count %0d",
					$time, got.mode_value, got.mode_count);
				mismatches++;
			end else begin
				want = expected_modes.pop_front();
				if (got.mode_value !== want.mode_value) begin
					$display("%0t: mode_value mismatch, expected %0d, actual %0d",
						$time, want.mode_value, got.mode_value);
					mismatches++;
				end
				if (got.mode_count !== want.mode_count) begin
					$display("%0t: mode_count mismatch, expected %0d, actual %0d",
						$time, want.mode_count, got.mode_count);
					mismatches++;
				end
			end
			if ($urandom_range(0, 7) == 0)
				recv_burst = !recv_burst;
			recv_gap = draw_gap(recv_burst);
		end
	end

	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int narrow;
		int random_beats;
		int v;
		int pool [4];

		foreach (bin_tally[i])
			bin_tally[i] = '0;

		// Single-beat frames at both ends of the value range
		push_beat(0, 1);
		push_beat(255, 1);
		// Tie goes to the smaller value, even after a larger one led
		push_beat(9, 0); push_beat(3, 0); push_beat(9, 0); push_beat(3, 1);
		push_beat(4, 0); push_beat(200, 0); push_beat(200, 0); push_beat(4, 1);
		// Larger value reaching an equal count does not take over
		push_beat(4, 0); push_beat(4, 0); push_beat(200, 0); push_beat(200, 1);
		// Same bin in consecutive beats (forwarding path when sent back to back)
		push_beat(17, 0); push_beat(17, 0); push_beat(17, 1);
		// Alternating bit patterns
		push_beat(8'hAA, 0); push_beat(8'h55, 0); push_beat(8'h55, 1);

		// Random frames, mostly short, some from a narrow pool so bins repeat and tie
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			len    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 24);
			narrow = $urandom_range(0, 1);
			foreach (pool[i])
				pool[i] = $urandom_range(0, 255);
			for (int i = 0; i < len; i++) begin
				v = narrow ? pool[$urandom_range(0, 3)] : $urandom_range(0, 255);
				push_beat(v, i == len - 1);
			end
			random_beats += len;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (beats_in < beats_total || expected_modes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d value beats sent, %0d frame results checked (ties, range ends,",
			beats_in, modes_seen);
		$display("back-to-back bins, random frames); %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/hmf_pkg.sv
hw/rtl/histogram_mode_finder_core.sv
sim/histogram_mode_finder_core_test.sv
